[rtl/core/tti_pkg.sv]
package tti_pkg;

  // input operation codes
  localparam logic [1:0] OP_LOAD_BP   = 2'd0;
  localparam logic [1:0] OP_LOAD_GRID = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_POINTS_A = 2'd0;
  localparam logic [1:0] REG_POINTS_B = 2'd1;
  localparam logic [1:0] REG_POINTS_C = 2'd2;
  localparam logic [1:0] REG_DEP_CNT  = 2'd3;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_BP_RD,
    CMD_BP_WB,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_DIV_DONE,
    CMD_GRID_RD,
    CMD_GRID_WB,
    CMD_LERP_MUL,
    CMD_LERP_ADD,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] axis;
    logic [2:0] corner;
    logic [2:0] lerp_idx;
    logic       col_err;
  } ctrl_t;

endpackage

[rtl/core/trilinear_table_interpolator_unit.sv]
// trilinear table interpolator
// input channel (in_valid_i/in_ready_o) carries one item: a breakpoint load,
// a grid value load or a query. loads give no result.
// a query gives one item on the output channel (out_valid_o/out_ready_i):
// interp_value_o and column_error_o.
// a query runs, per axis, a bracket search of 3 to 2 + log2(points) + 2
// breakpoint memory reads and a handoff, then a two-step-per-cycle restoring
// divider for the weight; then eight grid memory reads, seven multiply/add
// lerp steps and an output step, which loads the output register and raises
// out_valid_o. no new item is accepted until the query has left the output step.
// the breakpoint and grid memories give one registered read at a time and
// the divider is shared by the three axes.
// a column error skips the search and goes straight to the output step.
// the result sits in an output register; the next item is accepted while it
// waits unless the receiver stalls with a finished result still held.
// reset clears control state and sets the registers to their defaults;
// breakpoint and grid memories are undefined until loaded.
// registers sit on an apb port at byte address 4*index, pready always high.
module trilinear_table_interpolator_unit #(
  parameter int MAX_AXIS_POINTS = 16,
  parameter int MAX_COLUMNS     = 8,
  parameter int VALUE_WIDTH     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [1:0]  axis_select_i,
  input  logic [3:0]  point_a_i,
  input  logic [3:0]  point_b_i,
  input  logic [3:0]  point_c_i,
  input  logic [2:0]  column_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] coord_a_i,
  input  logic signed [31:0] coord_b_i,
  input  logic signed [31:0] coord_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] interp_value_o,
  output logic        column_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tti_pkg::*;

  logic [4:0] pts_a_q, pts_b_q, pts_c_q;
  logic [3:0] dep_q;
  logic [4:0] n_a, n_b, n_c;
  logic [3:0] dc;
  logic       col_err, search_done, out_load, err;
  logic signed [31:0] result, res_q;
  logic       res_err_q;
  ctrl_t      ctrl;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_a_q <= 5'd16;
      pts_b_q <= 5'd16;
      pts_c_q <= 5'd16;
      dep_q   <= 4'd8;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_POINTS_A: pts_a_q <= pwdata[4:0];
        REG_POINTS_B: pts_b_q <= pwdata[4:0];
        REG_POINTS_C: pts_c_q <= pwdata[4:0];
        REG_DEP_CNT:  dep_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POINTS_A: prdata = {27'd0, pts_a_q};
      REG_POINTS_B: prdata = {27'd0, pts_b_q};
      REG_POINTS_C: prdata = {27'd0, pts_c_q};
      default:      prdata = {28'd0, dep_q};
    endcase
  end

  // clamped counts
  function automatic logic [4:0] clamp_pts(input logic [4:0] r);
    logic [6:0] m;
    m = 7'(MAX_AXIS_POINTS);
    if (r < 5'd2) return 5'd2;
    if ({2'b0, r} > m) return 5'(MAX_AXIS_POINTS);
    return r;
  endfunction

  assign n_a = clamp_pts(pts_a_q);
  assign n_b = clamp_pts(pts_b_q);
  assign n_c = clamp_pts(pts_c_q);
  assign dc  = (dep_q == 4'd0) ? 4'd1 :
               ({2'b0, dep_q} > 6'(MAX_COLUMNS)) ? 4'(MAX_COLUMNS) : dep_q;
  assign col_err = ({1'b0, column_i} >= dc);

  tti_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .col_err_i     (col_err),
    .search_done_i (search_done),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_err_o     (err),
    .out_load_o    (out_load),
    .ctrl_o        (ctrl)
  );

  tti_datapath #(
    .MAX_AXIS_POINTS (MAX_AXIS_POINTS),
    .MAX_COLUMNS     (MAX_COLUMNS),
    .VALUE_WIDTH     (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .in_fire_i     (in_valid_i && in_ready_o),
    .op_i          (op_i),
    .axis_select_i (axis_select_i),
    .point_a_i     (point_a_i),
    .point_b_i     (point_b_i),
    .point_c_i     (point_c_i),
    .column_i      (column_i),
    .load_value_i  (load_value_i),
    .coord_a_i     (coord_a_i),
    .coord_b_i     (coord_b_i),
    .coord_c_i     (coord_c_i),
    .n_a_i         (n_a),
    .n_b_i         (n_b),
    .n_c_i         (n_c),
    .search_done_o (search_done),
    .result_o      (result)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q     <= result;
      res_err_q <= err;
    end
  end

  assign interp_value_o = res_q;
  assign column_error_o = res_err_q;

  // a column error result carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && column_error_o |-> interp_value_o == 32'sd0)
    else $error("column error with nonzero value");

  // a held result stays put while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(interp_value_o))
    else $error("stalled result changed");

  // no new item while a stalled result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("accepted input under output stall");

endmodule

[rtl/core/tti_datapath.sv]
module tti_datapath #(
  parameter int MAX_AXIS_POINTS = 16,
  parameter int MAX_COLUMNS     = 8,
  parameter int VALUE_WIDTH     = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tti_pkg::ctrl_t ctrl_i,
  input  logic          in_fire_i,
  input  logic [1:0]    op_i,
  input  logic [1:0]    axis_select_i,
  input  logic [3:0]    point_a_i,
  input  logic [3:0]    point_b_i,
  input  logic [3:0]    point_c_i,
  input  logic [2:0]    column_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] coord_a_i,
  input  logic signed [31:0] coord_b_i,
  input  logic signed [31:0] coord_c_i,
  input  logic [4:0]    n_a_i,
  input  logic [4:0]    n_b_i,
  input  logic [4:0]    n_c_i,
  output logic          search_done_o,
  output logic signed [31:0] result_o
);
  import tti_pkg::*;

  localparam int PW   = $clog2(MAX_AXIS_POINTS);
  localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int GAW  = 3 * PW + CW;
  localparam int GD   = 1 << GAW;
  localparam int BAW  = 2 + PW;
  localparam int VW   = VALUE_WIDTH;
  localparam logic signed [VW+1:0] VMAX = (VW+2)'((64'sd1 <<< (VW-1)) - 1);
  localparam logic signed [VW+1:0] VMIN = -VMAX - 1;

  // memories
  logic signed [31:0] bp_mem [4*MAX_AXIS_POINTS];
  logic signed [31:0] grid_mem [GD];
  logic signed [31:0] bp_rd_q, grid_rd_q;
  logic [BAW-1:0] bp_addr;
  logic [GAW-1:0] grid_addr;
  logic bp_we, grid_we;
  logic [BAW-1:0] bp_waddr;
  logic [GAW-1:0] grid_waddr;

  // query context
  logic signed [31:0] coord_q [3];
  logic [CW-1:0] col_q;

  // search state per axis
  logic [PW-1:0] lo_q [3];
  logic [PW-1:0] hi_q [3];
  logic [PW:0]   l_q, r_q;
  logic [2:0]    sphase_q;
  logic signed [31:0] p0_q, p1_q;
  logic          ext_q;
  logic          zero_w_q;
  logic          search_done_q;
  logic [4:0]    n_cur;
  logic signed [31:0] x_cur;

  // weights and divider
  logic signed [32:0] f_q [3];
  logic [48:0] rem_q, den_q;
  logic [49:0] quo_q;
  logic        neg_q;

  // lerp values
  logic signed [VW+1:0] v_q [8];
  logic signed [VW+1:0] prod_q;
  logic signed [VW+33:0] mul_q;

  assign bp_we    = in_fire_i && (op_i == OP_LOAD_BP) && (axis_select_i < 2'd3)
                    && ({1'b0, point_a_i} < 5'(MAX_AXIS_POINTS));
  assign bp_waddr = BAW'({axis_select_i, point_a_i[PW-1:0]});
  assign grid_we  = in_fire_i && (op_i == OP_LOAD_GRID)
                    && ({1'b0, point_a_i} < 5'(MAX_AXIS_POINTS))
                    && ({1'b0, point_b_i} < 5'(MAX_AXIS_POINTS))
                    && ({1'b0, point_c_i} < 5'(MAX_AXIS_POINTS))
                    && ({1'b0, column_i} < 4'(MAX_COLUMNS));
  assign grid_waddr = {point_a_i[PW-1:0], point_b_i[PW-1:0], point_c_i[PW-1:0],
                       column_i[CW-1:0]};

  always_comb begin
    n_cur = n_a_i;
    x_cur = coord_q[0];
    case (ctrl_i.axis)
      2'd1: begin n_cur = n_b_i; x_cur = coord_q[1]; end
      2'd2: begin n_cur = n_c_i; x_cur = coord_q[2]; end
      default: ;
    endcase
  end

  // search address: phase 0 first point, 1 last point, 2 bisection mid,
  // 3 read lo, 4 read hi
  always_comb begin
    logic [PW:0] idx;
    idx = '0;
    case (sphase_q)
      3'd0: idx = '0;
      3'd1: idx = (PW+1)'(n_cur - 5'd1);
      3'd2: idx = (l_q + r_q) >> 1;
      3'd3: idx = {1'b0, lo_q[ctrl_i.axis]};
      default: idx = {1'b0, hi_q[ctrl_i.axis]};
    endcase
    bp_addr = {ctrl_i.axis, idx[PW-1:0]};
  end

  // grid address per corner, order 000 100 010 001 110 101 011 111
  always_comb begin
    logic sa, sb, sc;
    sa = (ctrl_i.corner == 3'd1) || (ctrl_i.corner == 3'd4) || (ctrl_i.corner == 3'd5)
         || (ctrl_i.corner == 3'd7);
    sb = (ctrl_i.corner == 3'd2) || (ctrl_i.corner == 3'd4) || (ctrl_i.corner == 3'd6)
         || (ctrl_i.corner == 3'd7);
    sc = (ctrl_i.corner == 3'd3) || (ctrl_i.corner == 3'd5) || (ctrl_i.corner == 3'd6)
         || (ctrl_i.corner == 3'd7);
    grid_addr = {sa ? hi_q[0] : lo_q[0], sb ? hi_q[1] : lo_q[1],
                 sc ? hi_q[2] : lo_q[2], col_q};
  end

  // breakpoint memory
  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= load_value_i;
    end
    bp_rd_q <= bp_mem[bp_addr];
  end

  // grid memory
  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= load_value_i;
    end
    grid_rd_q <= grid_mem[grid_addr];
  end

  // search sequencer, divider and lerp datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sphase_q      <= '0;
      search_done_q <= 1'b0;
    end else begin
      case (ctrl_i.cmd)
        CMD_CAPTURE: begin
          coord_q[0]    <= coord_a_i;
          coord_q[1]    <= coord_b_i;
          coord_q[2]    <= coord_c_i;
          col_q         <= column_i[CW-1:0];
          sphase_q      <= '0;
          search_done_q <= 1'b0;
        end
        CMD_BP_RD: begin
          search_done_q <= 1'b0;
        end
        CMD_BP_WB: begin
          case (sphase_q)
            3'd0: begin
              l_q <= '0;
              r_q <= (PW+1)'(n_cur - 5'd1);
              if (x_cur < bp_rd_q) begin
                lo_q[ctrl_i.axis] <= PW'(0);
                hi_q[ctrl_i.axis] <= PW'(1);
                ext_q    <= 1'b1;
                sphase_q <= 3'd3;
              end else begin
                ext_q    <= 1'b0;
                sphase_q <= 3'd1;
              end
            end
            3'd1: begin
              if (x_cur > bp_rd_q) begin
                lo_q[ctrl_i.axis] <= PW'(n_cur - 5'd2);
                hi_q[ctrl_i.axis] <= PW'(n_cur - 5'd1);
                ext_q    <= 1'b1;
                sphase_q <= 3'd3;
              end else if (r_q - l_q >= 2) begin
                sphase_q <= 3'd2;
              end else begin
                lo_q[ctrl_i.axis] <= l_q[PW-1:0];
                hi_q[ctrl_i.axis] <= r_q[PW-1:0];
                sphase_q <= 3'd3;
              end
            end
            3'd2: begin
              logic [PW:0] m, nl, nr;
              m  = (l_q + r_q) >> 1;
              nl = l_q;
              nr = r_q;
              if (x_cur <= bp_rd_q) nr = m; else nl = m;
              l_q <= nl;
              r_q <= nr;
              if (nr - nl < 2) begin
                lo_q[ctrl_i.axis] <= nl[PW-1:0];
                hi_q[ctrl_i.axis] <= nr[PW-1:0];
                sphase_q <= 3'd3;
              end
            end
            3'd3: begin
              p0_q <= bp_rd_q;
              // exact hits collapse the bracket, except when extrapolating
              if (!ext_q && x_cur == bp_rd_q) begin
                hi_q[ctrl_i.axis] <= lo_q[ctrl_i.axis];
              end
              sphase_q <= 3'd4;
            end
            default: begin
              p1_q <= bp_rd_q;
              if (!ext_q && x_cur == bp_rd_q) begin
                lo_q[ctrl_i.axis] <= hi_q[ctrl_i.axis];
              end
              sphase_q      <= '0;
              search_done_q <= 1'b1;
            end
          endcase
        end
        CMD_DIV_START: begin
          logic signed [33:0] num, den;
          logic [33:0] an, ad;
          num = 34'(x_cur) - 34'(p0_q);
          den = 34'(p1_q) - 34'(p0_q);
          an  = num[33] ? 34'(-num) : num;
          ad  = den[33] ? 34'(-den) : den;
          search_done_q <= 1'b0;
          zero_w_q <= (lo_q[ctrl_i.axis] == hi_q[ctrl_i.axis]) || (den == 0);
          neg_q    <= num[33] ^ den[33];
          quo_q    <= {1'b0, an[32:0], 16'd0};
          rem_q    <= '0;
          den_q    <= 49'(ad);
        end
        CMD_DIV_STEP: begin
          // two restoring steps per cycle
          logic [49:0] t;
          logic [48:0] r;
          logic [49:0] qv;
          r  = rem_q;
          qv = quo_q;
          for (int i = 0; i < 2; i++) begin
            t  = {r, qv[49]};
            qv = {qv[48:0], 1'b0};
            if (t >= {1'b0, den_q}) begin
              r     = 49'(t - {1'b0, den_q});
              qv[0] = 1'b1;
            end else begin
              r = t[48:0];
            end
          end
          rem_q <= r;
          quo_q <= qv;
        end
        CMD_DIV_DONE: begin
          logic signed [50:0] s;
          s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
          if (zero_w_q)                      f_q[ctrl_i.axis] <= '0;
          else if (s > 51'sd2147483647)      f_q[ctrl_i.axis] <= 33'sd2147483647;
          else if (s < -51'sd2147483648)     f_q[ctrl_i.axis] <= -33'sd2147483648;
          else                               f_q[ctrl_i.axis] <= 33'(s);
        end
        CMD_GRID_RD: ;
        CMD_GRID_WB: begin
          v_q[ctrl_i.corner] <= (VW+2)'(grid_rd_q);
        end
        CMD_LERP_MUL: begin
          // lerp pairs: c00 c10 c01 c11 into 0 1 2 4, then b0 b1 into 0 1, then a
          logic signed [VW+1:0] a0, a1;
          logic signed [32:0]   fw;
          a0 = v_q[0]; a1 = v_q[3]; fw = f_q[2];
          case (ctrl_i.lerp_idx)
            3'd0: begin a0 = v_q[0]; a1 = v_q[3]; fw = f_q[2]; end
            3'd1: begin a0 = v_q[1]; a1 = v_q[5]; fw = f_q[2]; end
            3'd2: begin a0 = v_q[2]; a1 = v_q[6]; fw = f_q[2]; end
            3'd3: begin a0 = v_q[4]; a1 = v_q[7]; fw = f_q[2]; end
            3'd4: begin a0 = v_q[0]; a1 = v_q[2]; fw = f_q[1]; end
            3'd5: begin a0 = v_q[1]; a1 = v_q[4]; fw = f_q[1]; end
            default: begin a0 = v_q[0]; a1 = v_q[1]; fw = f_q[0]; end
          endcase
          prod_q <= a0;
          mul_q  <= (VW+34)'((a1 - a0) * fw);
        end
        CMD_LERP_ADD: begin
          logic signed [VW+17:0] s;
          logic signed [VW+1:0]  sv;
          s  = (VW+18)'(prod_q) + (VW+18)'(mul_q >>> 16);
          sv = (s > (VW+18)'(VMAX)) ? VMAX : (s < (VW+18)'(VMIN)) ? VMIN : (VW+2)'(s);
          case (ctrl_i.lerp_idx)
            3'd0: v_q[0] <= sv;
            3'd1: v_q[1] <= sv;
            3'd2: v_q[2] <= sv;
            3'd3: v_q[4] <= sv;
            3'd4: v_q[0] <= sv;
            3'd5: v_q[1] <= sv;
            default: v_q[0] <= sv;
          endcase
        end
        CMD_OUT: begin
          search_done_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign search_done_o = search_done_q;
  assign result_o      = ctrl_i.col_err ? 32'sd0 : 32'(v_q[0]);

endmodule

[rtl/core/tti_ctrl.sv]
module tti_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  input  logic          col_err_i,
  input  logic          search_done_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          out_err_o,
  output logic          out_load_o,
  output tti_pkg::ctrl_t ctrl_o
);
  import tti_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BP_RD  = 4'd1;
  localparam logic [3:0] S_BP_WB  = 4'd2;
  localparam logic [3:0] S_DIV0   = 4'd3;
  localparam logic [3:0] S_DIVS   = 4'd4;
  localparam logic [3:0] S_DIVD   = 4'd5;
  localparam logic [3:0] S_G_RD   = 4'd6;
  localparam logic [3:0] S_G_WB   = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_ADD    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [2:0] cnt_q, cnt_d;
  logic [4:0] step_q, step_d;
  logic       err_q, err_d;
  logic       ov_q, ov_d;
  logic       busy;

  assign busy       = (state_q != S_IDLE);
  assign in_ready_o = !busy && !(ov_q && !out_ready_i);

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    err_d   = err_q;
    ov_d    = ov_q && !out_ready_i;
    ctrl_o  = '{cmd: CMD_NONE, axis: axis_q, corner: cnt_q, lerp_idx: cnt_q,
                col_err: err_q};
    out_load_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o && op_i == OP_QUERY) begin
          ctrl_o.cmd = CMD_CAPTURE;
          err_d  = col_err_i;
          axis_d = 2'd0;
          state_d = col_err_i ? S_OUT : S_BP_RD;
        end
      end
      S_BP_RD: begin
        ctrl_o.cmd = CMD_BP_RD;
        state_d = S_BP_WB;
      end
      S_BP_WB: begin
        ctrl_o.cmd = CMD_BP_WB;
        state_d = S_BP_RD;
      end
      S_DIV0: begin
        ctrl_o.cmd = CMD_DIV_START;
        step_d = '0;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        ctrl_o.cmd = CMD_DIV_STEP;
        step_d = step_q + 5'd1;
        if (step_q == 5'd24) state_d = S_DIVD;
      end
      S_DIVD: begin
        ctrl_o.cmd = CMD_DIV_DONE;
        if (axis_q == 2'd2) begin
          cnt_d = '0;
          state_d = S_G_RD;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = S_BP_RD;
        end
      end
      S_G_RD: begin
        ctrl_o.cmd = CMD_GRID_RD;
        state_d = S_G_WB;
      end
      S_G_WB: begin
        ctrl_o.cmd = CMD_GRID_WB;
        cnt_d = cnt_q + 3'd1;
        state_d = (cnt_q == 3'd7) ? S_MUL : S_G_RD;
      end
      S_MUL: begin
        ctrl_o.cmd = CMD_LERP_MUL;
        state_d = S_ADD;
      end
      S_ADD: begin
        ctrl_o.cmd = CMD_LERP_ADD;
        cnt_d = cnt_q + 3'd1;
        state_d = (cnt_q == 3'd6) ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ctrl_o.cmd = CMD_OUT;
          out_load_o = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // search completion hands off to the divider
    if (state_q == S_BP_RD && search_done_i) begin
      ctrl_o.cmd = CMD_NONE;
      state_d = S_DIV0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= '0;
      cnt_q   <= '0;
      step_q  <= '0;
      err_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      err_q   <= err_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_err_o   = err_q;

endmodule

[sim/tti_checker.sv]
`timescale 1ns / 1ps

module tti_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [1:0]         axis_select_i,
  input  logic [3:0]         point_a_i,
  input  logic [3:0]         point_b_i,
  input  logic [3:0]         point_c_i,
  input  logic [2:0]         column_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] coord_a_i,
  input  logic signed [31:0] coord_b_i,
  input  logic signed [31:0] coord_c_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic signed [31:0] interp_value_o,
  input  logic               column_error_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o,
  output int                 col_errors_seen_o
);
  import tti_pkg::*;

  localparam int NPTS = 16;
  localparam int NCOL = 8;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] value;
    logic               col_err;
  } interp_result_t;

  // mirrored block state
  logic signed [31:0] axis_bp [3][NPTS];
  logic signed [31:0] grid_mem [NPTS*NPTS*NPTS*NCOL];
  logic [4:0] pts_reg [3];
  logic [3:0] dep_cnt_reg;
  interp_result_t expected_q [$];

  function automatic longint sat_val(input longint v);
    return v < VMIN ? VMIN : (v > VMAX ? VMAX : v);
  endfunction

  function automatic int grid_addr(input int a, input int b, input int c, input int col);
    return ((a * NPTS + b) * NPTS + c) * NCOL + col;
  endfunction

  // bisection for the breakpoints around x, with exact hit collapse
  function automatic void find_bracket(input int k, input int n, input longint x,
                                       output int lo, output int hi);
    int l, r, m;
    l = 0;
    r = n - 1;
    if (x < longint'(axis_bp[k][0])) begin
      lo = 0; hi = 1; return;
    end
    if (x > longint'(axis_bp[k][n-1])) begin
      lo = n - 2; hi = n - 1; return;
    end
    while (r - l >= 2) begin
      m = (l + r) / 2;
      if (x <= longint'(axis_bp[k][m])) r = m; else l = m;
    end
    if (x == longint'(axis_bp[k][l])) r = l;
    if (x == longint'(axis_bp[k][r])) l = r;
    lo = l;
    hi = r;
  endfunction

  function automatic longint frac_weight(input longint x, input longint p0, input longint p1);
    longint den, q;
    den = p1 - p0;
    if (den == 0) return 0;
    q = ((x - p0) * 65536) / den;
    return q < -64'sd2147483648 ? -64'sd2147483648 :
           (q > 64'sd2147483647 ? 64'sd2147483647 : q);
  endfunction

  function automatic longint blend(input longint v0, input longint v1, input longint f);
    longint p;
    p = (v1 - v0) * f;
    return sat_val(v0 + (p >>> 16));
  endfunction

  function automatic interp_result_t interpolate(input int col, input longint qa,
                                                 input longint qb, input longint qc);
    interp_result_t res;
    int n, dc, k;
    int lo [3];
    int hi [3];
    longint q [3];
    longint f [3];
    longint v [8];
    longint c00, c10, c01, c11, b0, b1;
    dc = dep_cnt_reg < 1 ? 1 : (dep_cnt_reg > NCOL ? NCOL : int'(dep_cnt_reg));
    if (col >= dc) begin
      res.value = '0;
      res.col_err = 1'b1;
      return res;
    end
    q[0] = qa; q[1] = qb; q[2] = qc;
    for (k = 0; k < 3; k++) begin
      n = pts_reg[k] < 2 ? 2 : (pts_reg[k] > NPTS ? NPTS : int'(pts_reg[k]));
      find_bracket(k, n, q[k], lo[k], hi[k]);
      f[k] = (lo[k] == hi[k]) ? 0 :
             frac_weight(q[k], axis_bp[k][lo[k]], axis_bp[k][hi[k]]);
    end
    // corner order a b c: 000 100 010 001 110 101 011 111
    v[0] = grid_mem[grid_addr(lo[0], lo[1], lo[2], col)];
    v[1] = grid_mem[grid_addr(hi[0], lo[1], lo[2], col)];
    v[2] = grid_mem[grid_addr(lo[0], hi[1], lo[2], col)];
    v[3] = grid_mem[grid_addr(lo[0], lo[1], hi[2], col)];
    v[4] = grid_mem[grid_addr(hi[0], hi[1], lo[2], col)];
    v[5] = grid_mem[grid_addr(hi[0], lo[1], hi[2], col)];
    v[6] = grid_mem[grid_addr(lo[0], hi[1], hi[2], col)];
    v[7] = grid_mem[grid_addr(hi[0], hi[1], hi[2], col)];
    c00 = blend(v[0], v[3], f[2]);
    c10 = blend(v[1], v[5], f[2]);
    c01 = blend(v[2], v[6], f[2]);
    c11 = blend(v[4], v[7], f[2]);
    b0  = blend(c00, c01, f[1]);
    b1  = blend(c10, c11, f[1]);
    res.value = 32'(blend(b0, b1, f[0]));
    res.col_err = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  assign pending_o = expected_q.size();

  initial begin
    fail_count_o = 0;
    results_seen_o = 0;
    col_errors_seen_o = 0;
  end

  // register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_reg[0] <= 5'd16;
      pts_reg[1] <= 5'd16;
      pts_reg[2] <= 5'd16;
      dep_cnt_reg <= 4'd8;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_POINTS_A: pts_reg[0] <= pwdata[4:0];
        REG_POINTS_B: pts_reg[1] <= pwdata[4:0];
        REG_POINTS_C: pts_reg[2] <= pwdata[4:0];
        REG_DEP_CNT:  dep_cnt_reg <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // accepted input items
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      case (op_i)
        OP_LOAD_BP: begin
          if (axis_select_i < 3) axis_bp[axis_select_i][point_a_i] = load_value_i;
        end
        OP_LOAD_GRID: begin
          grid_mem[grid_addr(point_a_i, point_b_i, point_c_i, column_i)] = load_value_i;
        end
        OP_QUERY: begin
          expected_q.push_back(interpolate(column_i, coord_a_i, coord_b_i, coord_c_i));
        end
        default: ;
      endcase
    end
  end

  // accepted result items
  always @(posedge clk_i) begin
    interp_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen_o++;
      if (expected_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.col_err) col_errors_seen_o++;
        if (column_error_o !== exp_r.col_err)
          report_mismatch($sformatf("column_error %b, expected %b",
                                    column_error_o, exp_r.col_err));
        if (interp_value_o !== exp_r.value)
          report_mismatch($sformatf("interp_value %0d, expected %0d",
                                    interp_value_o, exp_r.value));
      end
    end
  end

endmodule

[sim/tb_trilinear_table_interpolator_unit.sv]
`timescale 1ns / 1ps

module tb_trilinear_table_interpolator_unit;
  import tti_pkg::*;

  localparam int NPTS = 16;
  localparam int NCOL = 8;
  localparam int GRID_USED = 4;
  localparam int COLS_USED = 2;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 132;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         op_i;
  logic [1:0]         axis_select_i;
  logic [3:0]         point_a_i;
  logic [3:0]         point_b_i;
  logic [3:0]         point_c_i;
  logic [2:0]         column_i;
  logic signed [31:0] load_value_i;
  logic signed [31:0] coord_a_i;
  logic signed [31:0] coord_b_i;
  logic signed [31:0] coord_c_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] interp_value_o;
  logic               column_error_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int results_seen;
  int col_errors_seen;
  longint cycle_count;
  bit gaps_on;
  logic signed [31:0] axis_copy [3][NPTS];
  logic [4:0] pts_now [3];
  logic [3:0] dep_now;

  trilinear_table_interpolator_unit dut (.*);

  tti_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .axis_select_i,
    .point_a_i, .point_b_i, .point_c_i, .column_i, .load_value_i,
    .coord_a_i, .coord_b_i, .coord_c_i, .out_valid_o, .out_ready_i,
    .interp_value_o, .column_error_o, .psel, .penable, .pwrite, .pready,
    .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen), .col_errors_seen_o(col_errors_seen)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls: ready stretches and random stretches
  initial begin
    int run;
    out_ready_i = 1'b0;
    forever begin
      run = $urandom_range(1, 60);
      case ($urandom_range(0, 2))
        0: repeat (run) begin
          @(negedge clk_i);
          out_ready_i = 1'b1;
        end
        1: repeat (run) begin
          @(negedge clk_i);
          out_ready_i = ($urandom_range(0, 3) != 0);
        end
        default: repeat (run) begin
          @(negedge clk_i);
          out_ready_i = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // one item: called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [1:0] axis,
                           input logic [3:0] pa, input logic [3:0] pb, input logic [3:0] pc,
                           input logic [2:0] col, input logic [31:0] val,
                           input logic [31:0] ca, input logic [31:0] cb,
                           input logic [31:0] cc);
    int gap;
    op_i = op; axis_select_i = axis; point_a_i = pa; point_b_i = pb; point_c_i = pc;
    column_i = col; load_value_i = val; coord_a_i = ca; coord_b_i = cb; coord_c_i = cc;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    // bursts with random gaps between them
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 30);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic load_bp(input int axis, input int idx, input logic [31:0] val);
    send_item(OP_LOAD_BP, 2'(axis), 4'(idx), 4'($urandom), 4'($urandom), 3'($urandom),
              val, $urandom, $urandom, $urandom);
    if (axis < 3) axis_copy[axis][idx] = val;
  endtask

  task automatic load_grid(input int a, input int b, input int c, input int col,
                           input logic [31:0] val);
    send_item(OP_LOAD_GRID, 2'($urandom), 4'(a), 4'(b), 4'(c), 3'(col), val,
              $urandom, $urandom, $urandom);
  endtask

  // strictly increasing breakpoints, wide or narrow spacing
  task automatic load_sorted_axis(input int axis);
    longint p;
    longint step_max;
    int i;
    step_max = ($urandom_range(0, 1) != 0) ? 64'd67108864 : 64'd200000;
    p = -longint'($urandom_range(0, 32'h3fff_ffff));
    for (i = 0; i < NPTS; i++) begin
      load_bp(axis, i, 32'(p));
      p += longint'($urandom_range(1, 32'(step_max)));
    end
  endtask

  // a coordinate that hits a chosen region of an axis; it stays at or below
  // point 3 so that only the first four grid points of each axis are reached
  function automatic logic [31:0] pick_coord(input int axis);
    int n, i, top;
    longint lo_v, hi_v;
    n = pts_now[axis] < 2 ? 2 : (pts_now[axis] > NPTS ? NPTS : int'(pts_now[axis]));
    top = (n < 4) ? n - 1 : 3;
    case ($urandom_range(0, 7))
      0: return axis_copy[axis][$urandom_range(0, top)];
      1: return 32'(longint'(axis_copy[axis][0]) - $urandom_range(1, 32'h00ff_ffff));
      2: begin
        if (n < 4)
          return 32'(longint'(axis_copy[axis][n-1]) + $urandom_range(1, 32'h00ff_ffff));
        return axis_copy[axis][3];
      end
      3: return 32'h8000_0000;
      4: return (n < 4) ? 32'h7fff_ffff : 32'h8000_0000;
      default: begin
        i = $urandom_range(0, top - 1);
        lo_v = axis_copy[axis][i];
        hi_v = axis_copy[axis][i+1];
        if (hi_v <= lo_v) return 32'(lo_v);
        return 32'(lo_v + longint'($urandom_range(0, 32'(hi_v - lo_v))));
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_grid_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  // a loaded column, or a column at or beyond the count in use
  function automatic int pick_col();
    int dcl;
    dcl = dep_now < 1 ? 1 : (dep_now > NCOL ? NCOL : int'(dep_now));
    if (dcl < NCOL && $urandom_range(0, 3) == 0) return $urandom_range(dcl, NCOL - 1);
    return $urandom_range(0, COLS_USED - 1);
  endfunction

  task automatic query();
    send_item(OP_QUERY, 2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
              3'(pick_col()), $urandom, pick_coord(0), pick_coord(1), pick_coord(2));
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == REG_DEP_CNT) dep_now = val[3:0];
    else pts_now[idx] = val[4:0];
  endtask

  // wait until every expected result is in, then let loads drain
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [4:0] na, input logic [4:0] nb,
                            input logic [4:0] nc, input logic [3:0] dc);
    settle();
    reg_write(REG_POINTS_A, 32'(na));
    reg_write(REG_POINTS_B, 32'(nb));
    reg_write(REG_POINTS_C, 32'(nc));
    reg_write(REG_DEP_CNT, {28'($urandom_range(0, 32'h0fff_ffff)), dc});
  endtask

  initial begin
    int a, b, c, col, phase, k, sel;
    rst_ni = 1'b0;
    in_valid_i = 1'b0; op_i = '0; axis_select_i = '0; point_a_i = '0; point_b_i = '0;
    point_c_i = '0; column_i = '0; load_value_i = '0; coord_a_i = '0; coord_b_i = '0;
    coord_c_i = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gaps_on = 1'b0;
    pts_now[0] = 5'd16; pts_now[1] = 5'd16; pts_now[2] = 5'd16;
    dep_now = 4'd8;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill every breakpoint and the part of the grid that queries can reach
    for (k = 0; k < 3; k++) load_sorted_axis(k);
    for (a = 0; a < GRID_USED; a++)
      for (b = 0; b < GRID_USED; b++)
        for (c = 0; c < GRID_USED; c++)
          for (col = 0; col < COLS_USED; col++)
            load_grid(a, b, c, col, pick_grid_value());

    // directed: extremes, exact hits, extrapolation, ignored items
    gaps_on = 1'b1;
    send_item(OP_QUERY, 2'd0, 4'd0, 4'd0, 4'd0, 3'd0, 32'd0,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_QUERY, 2'd3, 4'hf, 4'hf, 4'hf, 3'd1, 32'hffff_ffff,
              32'h8000_0000, axis_copy[1][3], axis_copy[2][0]);
    send_item(OP_QUERY, 2'd0, 4'd0, 4'd0, 4'd0, 3'd1, 32'd0,
              axis_copy[0][0], axis_copy[1][3], axis_copy[2][2]);
    send_item(2'd3, 2'd0, 4'd0, 4'd0, 4'd0, 3'd0, $urandom, $urandom, $urandom, $urandom);
    send_item(OP_LOAD_BP, 2'd3, 4'hf, 4'd0, 4'd0, 3'd0, 32'hffff_ffff,
              $urandom, $urandom, $urandom);
    load_grid(3, 3, 3, 1, 32'h7fff_ffff);
    load_grid(0, 0, 0, 0, 32'h8000_0000);
    for (k = 0; k < 4; k++) query();
    // repeated and unsorted breakpoints
    load_bp(1, 2, axis_copy[1][1]);
    load_bp(2, 0, axis_copy[2][2]);
    for (k = 0; k < 6; k++) query();
    load_sorted_axis(1);
    load_sorted_axis(2);

    // random phases with different register settings, extremes among them
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(5'd2, 5'd2, 5'd2, 4'd1);
        1: set_config(5'd0, 5'd31, 5'd1, 4'd0);
        2: set_config(5'd16, 5'd16, 5'd16, 4'd8);
        3: set_config(5'd17, 5'd3, 5'd9, 4'd15);
        default: set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                            5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
      endcase
      for (k = 0; k < RANDOM_ITEMS / 6; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) query();
        else if (sel < 80) load_sorted_axis($urandom_range(0, 2));
        else if (sel < 93)
          load_grid($urandom_range(0, GRID_USED - 1), $urandom_range(0, GRID_USED - 1),
                    $urandom_range(0, GRID_USED - 1), $urandom_range(0, COLS_USED - 1),
                    pick_grid_value());
        else if (sel < 96) begin
          // repeat a point among the first ones, keeping them at or below point 3
          a = $urandom_range(0, 2);
          load_bp(a, $urandom_range(0, 2), axis_copy[a][$urandom_range(0, 3)]);
        end
        else if (sel < 98)
          send_item(2'd3, 2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                    3'($urandom), $urandom, $urandom, $urandom, $urandom);
        else
          send_item(OP_LOAD_BP, 2'd3, 4'($urandom), 4'($urandom), 4'($urandom),
                    3'($urandom), $urandom, $urandom, $urandom, $urandom);
      end
    end

    settle();
    $display("covered a fill of the reachable grid corners, directed edge queries,");
    $display("repeated and unsorted breakpoints and six register settings");
    $display("%0d results checked, %0d with column error, %0d mismatches",
             results_seen, col_errors_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
